// ----- rtl/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, substitution tables and round functions of the block cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package aes_pkg;

    localparam int COLUMNS         = 4;
    localparam int ROUND_KEY_DEPTH = 60;
    localparam int MAX_ROUNDS      = 14;
    localparam int NUM_STAGES      = MAX_ROUNDS + 1;

    localparam logic [2:0] REG_KEY_0   = 3'd0;
    localparam logic [2:0] REG_KEY_1   = 3'd1;
    localparam logic [2:0] REG_KEY_2   = 3'd2;
    localparam logic [2:0] REG_KEY_3   = 3'd3;
    localparam logic [2:0] REG_KEY_LEN = 3'd4;

    localparam logic [1:0] KEY_LEN_128 = 2'd0;
    localparam logic [1:0] KEY_LEN_192 = 2'd1;

    localparam logic [0:0] KIND_ENCRYPT = 1'b0;

    localparam logic [7:0] RCON_FIRST = 8'h01;

    typedef enum logic [1:0] {
        OP_FULL,
        OP_FINAL,
        OP_PASS
    } stage_op_t;

    typedef enum logic {
        KS_IDLE,
        KS_EXPAND
    } ks_state_t;

    typedef struct packed {
        logic valid;
        logic kind;
    } stage_ctrl_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte j of the state sits in bits 127-8j down to 120-8j
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int j = 0; j < 16; j++) begin
            r[127 - 8*j -: 8] = inv ? INV_SBOX[s[127 - 8*j -: 8]] : SBOX[s[127 - 8*j -: 8]];
        end
        sub_bytes = r;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                if (inv) begin
                    r[127 - 8*(k + 4*((c + k) % 4)) -: 8] = s[127 - 8*(k + 4*c) -: 8];
                end else begin
                    r[127 - 8*(k + 4*c) -: 8] = s[127 - 8*(k + 4*((c + k) % 4)) -: 8];
                end
            end
        end
        shift_rows = r;
    endfunction

    function automatic logic [31:0] mix_column(input logic [31:0] col, input logic inv);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m [4][4];
        logic [31:0] r;
        r = '0;
        for (int k = 0; k < 4; k++) begin
            a[k]  = col[31 - 8*k -: 8];
            x2[k] = xtime(a[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            // multiples by the coefficients 2, 3, 1, 1 or 14, 11, 13, 9
            m[k][0] = inv ? (x8[k] ^ x4[k] ^ x2[k]) : x2[k];
            m[k][1] = inv ? (x8[k] ^ x2[k] ^ a[k]) : (x2[k] ^ a[k]);
            m[k][2] = inv ? (x8[k] ^ x4[k] ^ a[k]) : a[k];
            m[k][3] = inv ? (x8[k] ^ a[k]) : a[k];
        end
        for (int q = 0; q < 4; q++) begin
            r[31 - 8*q -: 8] = m[0][(4 - q) % 4] ^ m[1][(5 - q) % 4]
                             ^ m[2][(6 - q) % 4] ^ m[3][(7 - q) % 4];
        end
        mix_column = r;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[127 - 32*c -: 32] = mix_column(s[127 - 32*c -: 32], inv);
        end
        mix_columns = r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/aes_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// aes_block_cipher_unit
// AES-128/192/256 encrypt and decrypt, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Fully pipelined: one item may enter every cycle and passes through
// an initial key-add stage and 14 round stages (shorter
// keys pass the spare stages through). A stalled output holds the whole
// pipeline. After reset and after every configuration write the key
// schedule is rebuilt one word per cycle, 44, 52 or 60 words for a 128,
// 192 or 256-bit key, and s_ready stays low until it is complete.
`default_nettype none

module aes_block_cipher_unit
    import aes_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic         s_kind,
    input  wire logic [63:0]  s_block_high,
    input  wire logic [63:0]  s_block_low,
    output logic              m_valid,
    input  wire logic         m_ready,
    output logic [63:0]       m_result_high,
    output logic [63:0]       m_result_low,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [63:0]  cfg_data
);

    logic [63:0]  key_reg [4];
    logic [1:0]   key_len_reg;
    logic [31:0]  w_reg [ROUND_KEY_DEPTH];
    logic [31:0]  win_reg [8];
    logic [5:0]   idx_reg;
    logic [2:0]   pos_reg;
    logic [7:0]   rcon_reg;
    ks_state_t    ks_state_reg;
    ks_state_t    ks_state_next;

    logic         cfg_wr;
    logic         ks_busy;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [5:0]   ks_last;
    logic [31:0]  key_word;
    logic [31:0]  prev_nk;
    logic [31:0]  t_word;
    logic [31:0]  new_word;
    logic         use_rcon;

    logic         en;
    logic [127:0] rk_all [NUM_STAGES];
    stage_ctrl_t  ctrl_s [NUM_STAGES];
    logic [127:0] data_s [NUM_STAGES];
    stage_ctrl_t  ctrl0_reg;
    logic [127:0] data0_reg;
    logic [127:0] first_key;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg[0]  <= '0;
            key_reg[1]  <= '0;
            key_reg[2]  <= '0;
            key_reg[3]  <= '0;
            key_len_reg <= KEY_LEN_128;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_KEY_0:   key_reg[0]  <= cfg_data;
                REG_KEY_1:   key_reg[1]  <= cfg_data;
                REG_KEY_2:   key_reg[2]  <= cfg_data;
                REG_KEY_3:   key_reg[3]  <= cfg_data;
                REG_KEY_LEN: key_len_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // key length code 3 behaves as 256-bit
    always_comb begin
        case (key_len_reg)
            KEY_LEN_128: begin
                nk = 4'd4;  nr = 4'd10; ks_last = 6'd43; prev_nk = win_reg[3];
            end
            KEY_LEN_192: begin
                nk = 4'd6;  nr = 4'd12; ks_last = 6'd51; prev_nk = win_reg[5];
            end
            default: begin
                nk = 4'd8;  nr = 4'd14; ks_last = 6'd59; prev_nk = win_reg[7];
            end
        endcase
    end

    // key schedule sequencer
    always_comb begin
        case (ks_state_reg)
            KS_IDLE:   ks_state_next = KS_IDLE;
            KS_EXPAND: ks_state_next = (idx_reg == ks_last) ? KS_IDLE : KS_EXPAND;
            default:   ks_state_next = KS_IDLE;
        endcase
        if (cfg_wr) begin
            ks_state_next = KS_EXPAND;
        end
    end

    always_comb begin
        case (ks_state_reg)
            KS_EXPAND: ks_busy = 1'b1;
            default:   ks_busy = 1'b0;
        endcase
    end

    always_comb begin
        key_word = idx_reg[0] ? key_reg[idx_reg[2:1]][31:0] : key_reg[idx_reg[2:1]][63:32];
        use_rcon = (idx_reg >= {2'b00, nk}) && (pos_reg == 3'd0);
        t_word   = win_reg[0];
        if (use_rcon) begin
            t_word = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h000000};
        end else if ((nk == 4'd8) && (pos_reg == 3'd4)) begin
            t_word = sub_word(win_reg[0]);
        end
        new_word = (idx_reg < {2'b00, nk}) ? key_word : (prev_nk ^ t_word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ks_state_reg <= KS_EXPAND;
            idx_reg      <= '0;
            pos_reg      <= '0;
            rcon_reg     <= RCON_FIRST;
        end else begin
            ks_state_reg <= ks_state_next;
            if (cfg_wr) begin
                idx_reg  <= '0;
                pos_reg  <= '0;
                rcon_reg <= RCON_FIRST;
            end else if (ks_busy) begin
                idx_reg  <= idx_reg + 6'd1;
                pos_reg  <= ({1'b0, pos_reg} == nk - 4'd1) ? 3'd0 : pos_reg + 3'd1;
                if (use_rcon) begin
                    rcon_reg <= xtime(rcon_reg);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ks_busy && !cfg_wr) begin
            w_reg[idx_reg] <= new_word;
            win_reg[0]     <= new_word;
            for (int k = 1; k < 8; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
        end
    end

    for (genvar r = 0; r < NUM_STAGES; r++) begin : g_rk
        assign rk_all[r] = {w_reg[COLUMNS*r], w_reg[COLUMNS*r+1],
                            w_reg[COLUMNS*r+2], w_reg[COLUMNS*r+3]};
    end

    // pipeline
    assign en      = !m_valid || m_ready;
    assign s_ready = en && !ks_busy;

    always_comb begin
        case (key_len_reg)
            KEY_LEN_128: first_key = rk_all[10];
            KEY_LEN_192: first_key = rk_all[12];
            default:     first_key = rk_all[14];
        endcase
        if (s_kind == KIND_ENCRYPT) begin
            first_key = rk_all[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl0_reg <= '0;
        end else if (en) begin
            ctrl0_reg.valid <= s_valid && s_ready;
            ctrl0_reg.kind  <= s_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data0_reg <= {s_block_high, s_block_low} ^ first_key;
        end
    end

    assign ctrl_s[0] = ctrl0_reg;
    assign data_s[0] = data0_reg;

    for (genvar s = 1; s < NUM_STAGES; s++) begin : g_stage
        localparam int D10 = (10 - s > 0) ? 10 - s : 0;
        localparam int D12 = (12 - s > 0) ? 12 - s : 0;
        localparam int D14 = (14 - s > 0) ? 14 - s : 0;
        stage_op_t    op;
        logic [127:0] dec_key;

        always_comb begin
            if (4'(s) < nr) begin
                op = OP_FULL;
            end else if (4'(s) == nr) begin
                op = OP_FINAL;
            end else begin
                op = OP_PASS;
            end
            case (key_len_reg)
                KEY_LEN_128: dec_key = rk_all[D10];
                KEY_LEN_192: dec_key = rk_all[D12];
                default:     dec_key = rk_all[D14];
            endcase
        end

        aes_round u_round (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .op       (op),
            .enc_key  (rk_all[s]),
            .dec_key  (dec_key),
            .ctrl_in  (ctrl_s[s-1]),
            .data_in  (data_s[s-1]),
            .ctrl_out (ctrl_s[s]),
            .data_out (data_s[s])
        );
    end

    assign m_valid       = ctrl_s[NUM_STAGES-1].valid;
    assign m_result_high = data_s[NUM_STAGES-1][127:64];
    assign m_result_low  = data_s[NUM_STAGES-1][63:0];

endmodule

`default_nettype wire

// ----- rtl/aes_round.sv -----
// ----------------------------------------------------------------------------
// aes_round
// One registered round stage: full round, final round or pass, either
// direction, chosen by the item's kind.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_round
    import aes_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         en,
    input  wire stage_op_t    op,
    input  wire logic [127:0] enc_key,
    input  wire logic [127:0] dec_key,
    input  wire stage_ctrl_t  ctrl_in,
    input  wire logic [127:0] data_in,
    output stage_ctrl_t       ctrl_out,
    output logic [127:0]      data_out
);

    stage_ctrl_t  ctrl_reg;
    logic [127:0] data_reg;
    logic [127:0] data_next;
    logic [127:0] enc_mid;
    logic [127:0] dec_mid;

    always_comb begin
        enc_mid = shift_rows(sub_bytes(data_in, 1'b0), 1'b0);
        dec_mid = sub_bytes(shift_rows(data_in, 1'b1), 1'b1) ^ dec_key;
        case (op)
            OP_FULL: begin
                if (ctrl_in.kind == KIND_ENCRYPT) begin
                    data_next = mix_columns(enc_mid, 1'b0) ^ enc_key;
                end else begin
                    data_next = mix_columns(dec_mid, 1'b1);
                end
            end
            OP_FINAL: begin
                if (ctrl_in.kind == KIND_ENCRYPT) begin
                    data_next = enc_mid ^ enc_key;
                end else begin
                    data_next = dec_mid;
                end
            end
            default: begin
                data_next = data_in;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign data_out = data_reg;

endmodule

`default_nettype wire

// ----- rtl/aes_checker.sv -----
// ----------------------------------------------------------------------------
// aes_checker
// Port-level checks of the cipher unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aes_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_result_high,
    input wire logic [63:0] m_result_low,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_high) && $stable(m_result_low))
        else $error("result changed while stalled");

    // key rebuild after a register write blocks new items
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_ready)
        else $error("item taken during key schedule rebuild");

    // reset empties the pipeline and starts the key schedule
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("pipeline not clear after reset");

endmodule

bind aes_block_cipher_unit aes_checker u_aes_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_result_high (m_result_high),
    .m_result_low  (m_result_low),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

`default_nettype wire
